// ===== design/bqs_pkg.sv =====
package bqs_pkg;

	localparam int TIME_W = 48;
	localparam int ARR_W = 40;
	localparam int DUR_W = 40;
	localparam int ID_W = 20;
	localparam int LIM_W = 5;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam logic [LIM_W-1:0] LIMIT_RESET = 5'd16;

	localparam int S_DATA_W = ARR_W + DUR_W;
	localparam int M_DATA_W = ((ID_W + TIME_W + 7) / 8) * 8;

	localparam logic OP_ARRIVAL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_WAIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic drain;
		logic serve;
		logic enqueue;
		logic reject;
	} cmd_t;

	typedef struct packed {
		logic flush;
		logic count_nz;
		logic busy_le_t;
		logic room;
		logic out_free;
	} status_t;

endpackage

// ===== design/bqs_ctrl.sv =====
module bqs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  bqs_pkg::status_t sts,
	output bqs_pkg::cmd_t    cmd
);
	import bqs_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.flush) begin
					if (!sts.count_nz) begin
						state_d = ST_IDLE;
					end else if (sts.out_free) begin
						cmd.drain = 1'b1;
						state_d = ST_WAIT;
					end
				end else if (sts.count_nz && sts.busy_le_t) begin
					if (sts.out_free) begin
						cmd.drain = 1'b1;
						state_d = ST_WAIT;
					end
				end else if (!sts.busy_le_t && sts.room) begin
					cmd.enqueue = 1'b1;
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					if (sts.busy_le_t) begin
						cmd.serve = 1'b1;
					end else begin
						cmd.reject = 1'b1;
					end
					state_d = ST_IDLE;
				end
			end
			// head entry read settles
			ST_WAIT: begin
				state_d = ST_CHECK;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/bqs_dp.sv =====
module bqs_dp #(
	parameter int QUEUE_DEPTH = bqs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [bqs_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bqs_pkg::M_DATA_W-1:0]  m_tdata,
	output logic                          m_tuser,
	output logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic [bqs_pkg::LIM_W-1:0]     cfg_wdata,
	input  bqs_pkg::cmd_t                 cmd,
	output bqs_pkg::status_t              sts
);
	import bqs_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	logic [LIM_W-1:0]  limit_q;
	logic [TIME_W-1:0] busy_q;
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [CNT_W-1:0]  count_q;
	logic [ID_W-1:0]   next_id_q;

	logic              op_q;
	logic [ARR_W-1:0]  t_q;
	logic [DUR_W-1:0]  d_q;
	logic [ID_W-1:0]   id_q;

	logic [DUR_W-1:0]  mem_dur_q [QUEUE_DEPTH];
	logic [ID_W-1:0]   mem_id_q [QUEUE_DEPTH];
	logic [DUR_W-1:0]  rd_dur_q;
	logic [ID_W-1:0]   rd_id_q;

	logic              m_tvalid_q;
	logic [ID_W-1:0]   out_id_q;
	logic [TIME_W-1:0] out_fin_q;
	logic              out_rej_q;
	logic              out_last_q;

	logic [31:0]       lim;
	logic [TIME_W:0]   drain_sum;
	logic [TIME_W-1:0] drain_busy;
	logic [TIME_W-1:0] serve_busy;
	logic [TIME_W-1:0] t_ext;
	logic              drain_le_t;
	logic              drain_room;
	logic              drain_last;
	logic              emit;
	logic              out_free;

	assign lim = (32'(limit_q) < 32'(QUEUE_DEPTH)) ? 32'(limit_q) : 32'(QUEUE_DEPTH);
	assign t_ext = TIME_W'(t_q);

	assign drain_sum = {1'b0, busy_q} + (TIME_W + 1)'(rd_dur_q);
	assign drain_busy = drain_sum[TIME_W] ? '1 : drain_sum[TIME_W-1:0];
	assign serve_busy = t_ext + TIME_W'(d_q);

	// last drained result unless more drains or the new job's own result follow
	assign drain_le_t = drain_busy <= t_ext;
	assign drain_room = 32'(count_q - CNT_W'(1)) < lim;
	assign drain_last = (op_q == OP_FLUSH) ? (count_q == CNT_W'(1))
		: !drain_le_t && drain_room;

	assign emit = cmd.drain || cmd.serve || cmd.reject;
	assign out_free = !m_tvalid_q || m_tready;

	assign sts.flush = op_q == OP_FLUSH;
	assign sts.count_nz = count_q != '0;
	assign sts.busy_le_t = busy_q <= t_ext;
	assign sts.room = 32'(count_q) < lim;
	assign sts.out_free = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			busy_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			next_id_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (cmd.accept && s_tuser == OP_ARRIVAL) begin
				next_id_q <= next_id_q + ID_W'(1);
			end
			if (cmd.drain) begin
				busy_q <= drain_busy;
				head_q <= (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
				count_q <= count_q - CNT_W'(1);
			end else if (cmd.enqueue) begin
				tail_q <= (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.serve) begin
				busy_q <= serve_busy;
			end
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= s_tuser;
			t_q <= s_tdata[ARR_W-1:0];
			d_q <= s_tdata[S_DATA_W-1:ARR_W];
			id_q <= next_id_q;
		end
		if (cmd.enqueue) begin
			mem_dur_q[tail_q] <= d_q;
			mem_id_q[tail_q] <= id_q;
		end
		rd_dur_q <= mem_dur_q[head_q];
		rd_id_q <= mem_id_q[head_q];
		if (cmd.drain) begin
			out_id_q <= rd_id_q;
			out_fin_q <= drain_busy;
			out_rej_q <= 1'b0;
			out_last_q <= drain_last;
		end else if (cmd.serve) begin
			out_id_q <= id_q;
			out_fin_q <= serve_busy;
			out_rej_q <= 1'b0;
			out_last_q <= 1'b1;
		end else if (cmd.reject) begin
			out_id_q <= id_q;
			out_fin_q <= '0;
			out_rej_q <= 1'b1;
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = M_DATA_W'({out_fin_q, out_id_q});
	assign m_tuser = out_rej_q;
	assign m_tlast = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drain |-> count_q != '0)
		else $error("drain from empty queue");

	a_enqueue_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enqueue |-> sts.room && !sts.busy_le_t && !sts.flush)
		else $error("enqueue without room or with idle server");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("pending result overwritten");

endmodule

// ===== design/bounded_queue_server_sim.sv =====
// Single server with bounded waiting queue and tail drop.
// A request's own result is registered onto m_tvalid after the results of any queued
// jobs drained ahead of it; an m_tready stall holds it back. A new request is taken
// only in the idle state, once the previous request and its drains are done; each
// drain, also in a flush, waits for the registered read of the queue memory.
// Reset (arst_n, asynchronous): queue empty, busy-until and job id zero, limit 16.
module bounded_queue_server_sim #(
	parameter int QUEUE_DEPTH = bqs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bqs_pkg::S_DATA_W-1:0]  s_tdata,   // arrival_time, duration
	input  logic                          s_tuser,   // op
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bqs_pkg::M_DATA_W-1:0]  m_tdata,   // job_id, finish_time, zero pad
	output logic                          m_tuser,   // rejected
	output logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic [bqs_pkg::LIM_W-1:0]     cfg_wdata
);
	import bqs_pkg::*;

	cmd_t    cmd;
	status_t sts;

	bqs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bqs_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import bqs_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH_DEF;
	localparam int HOLD_OFF = 8;
	localparam int STALL_LIMIT = 2000;
	localparam logic [ARR_W-1:0] ARR_MAX = '1;
	localparam logic [DUR_W-1:0] DUR_MAX = '1;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam int N_PLAN = 19;
	localparam int N_PHASE = 6;
	localparam int FULL_ROUNDS = 3;

	typedef struct {
		logic [ID_W-1:0] id;
		logic [TIME_W-1:0] fin;
		logic rej;
		logic last;
	} result_t;

	typedef enum {ROW_ARRIVAL, ROW_FLUSH, ROW_LIMIT} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic [ARR_W-1:0] t;
		logic [DUR_W-1:0] d;
		logic [LIM_W-1:0] lim;
		bit typed;
		logic [ID_W-1:0] id;
		logic [TIME_W-1:0] fin;
		logic rej;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic m_tuser;
	logic m_tlast;
	logic cfg_we;
	logic [LIM_W-1:0] cfg_wdata;

	always #6 clk = ~clk;

	bounded_queue_server_sim u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// server model
	logic [TIME_W-1:0] srv_busy;
	logic [DUR_W-1:0] wait_dur [DEPTH];
	logic [ID_W-1:0] wait_id [DEPTH];
	int wait_head;
	int wait_tail;
	int wait_count;
	logic [ID_W-1:0] srv_next_id;
	logic [LIM_W-1:0] srv_limit;

	result_t caused[$];
	result_t pending_results[$];
	int mismatches = 0;
	int send_gap_max = 4;
	int recv_gap_max = 4;
	int idle_cycles = 0;
	logic [ARR_W-1:0] t_now;
	result_t want;
	plan_row_t plan [N_PLAN];

	function automatic logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] a, logic [DUR_W-1:0] b);
		logic [TIME_W:0] s;
		s = a + b;
		return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
	endfunction

	function automatic logic [39:0] rand40();
		return 40'({$urandom(), $urandom()});
	endfunction

	function automatic void note_result(logic [ID_W-1:0] id, logic [TIME_W-1:0] fin, logic rej);
		result_t r;
		r.id = id;
		r.fin = fin;
		r.rej = rej;
		r.last = 1'b0;
		caused.insert(caused.size(), r);
	endfunction

	function automatic void drain_oldest();
		srv_busy = sat_add(srv_busy, wait_dur[wait_head]);
		note_result(wait_id[wait_head], srv_busy, 1'b0);
		wait_head = (wait_head + 1) % DEPTH;
		wait_count--;
	endfunction

	function automatic void advance_server(logic op, logic [ARR_W-1:0] t, logic [DUR_W-1:0] d);
		logic [ID_W-1:0] id;
		int lim;
		caused.delete();
		if (op == OP_FLUSH) begin
			while (wait_count > 0)
				drain_oldest();
		end else begin
			id = srv_next_id;
			srv_next_id = srv_next_id + 1'b1;
			lim = (int'(srv_limit) < DEPTH) ? int'(srv_limit) : DEPTH;
			while (wait_count > 0 && srv_busy <= TIME_W'(t))
				drain_oldest();
			if (srv_busy > TIME_W'(t)) begin
				if (wait_count < lim) begin
					wait_dur[wait_tail] = d;
					wait_id[wait_tail] = id;
					wait_tail = (wait_tail + 1) % DEPTH;
					wait_count++;
				end else begin
					note_result(id, '0, 1'b1);
				end
			end else begin
				srv_busy = sat_add(TIME_W'(t), d);
				note_result(id, srv_busy, 1'b0);
			end
		end
		if (caused.size() > 0)
			caused[caused.size()-1].last = 1'b1;
	endfunction

	task automatic send_request(input logic op, input logic [ARR_W-1:0] t,
			input logic [DUR_W-1:0] d);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {d, t};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic issue(input logic op, input logic [ARR_W-1:0] t, input logic [DUR_W-1:0] d);
		send_request(op, t, d);
		advance_server(op, t, d);
		foreach (caused[i])
			pending_results.insert(pending_results.size(), caused[i]);
	endtask

	task automatic settle_queue();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (HOLD_OFF) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIM_W-1:0] v);
		settle_queue();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		srv_limit = v;
	endtask

	function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
		if (got_v !== exp_v) begin
			mismatches++;
			$display("%0t: %s expected %0h got %0h", $time, name, exp_v, got_v);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none got id %0h fin %0h rej %b last %b",
					$time, m_tdata[ID_W-1:0], m_tdata[ID_W+TIME_W-1:ID_W], m_tuser, m_tlast);
			end else begin
				want = pending_results.pop_front();
				check_field("job_id", 64'(want.id), 64'(m_tdata[ID_W-1:0]));
				check_field("finish_time", 64'(want.fin), 64'(m_tdata[ID_W+TIME_W-1:ID_W]));
				check_field("rejected", 64'(want.rej), 64'(m_tuser));
				check_field("last", 64'(want.last), 64'(m_tlast));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("bounded_queue_server_sim regression: fail");
				$finish;
			end
		end
	end

	initial begin : result_sink
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, recv_gap_max);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin : stimulus
		int r;
		int phase_limit [N_PHASE];
		int phase_dur [N_PHASE];
		logic [ARR_W-1:0] t;
		logic [DUR_W-1:0] d;
		result_t typed_res;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_ARRIVAL;
		cfg_we = 1'b0;
		cfg_wdata = '0;

		srv_busy = '0;
		wait_head = 0;
		wait_tail = 0;
		wait_count = 0;
		srv_next_id = '0;
		srv_limit = LIMIT_RESET;

		// busy-until equal to arrival, zero duration, flush on empty queue,
		// zero limit, decreasing arrival, limit above capacity
		plan = '{
			'{ROW_ARRIVAL, 40'd0,  40'd5,   5'd0,  1'b1, 20'd0,  48'd5,  1'b0},
			'{ROW_ARRIVAL, 40'd2,  40'd3,   5'd0,  1'b0, 20'd0,  48'd0,  1'b0},
			'{ROW_ARRIVAL, 40'd3,  40'd0,   5'd0,  1'b0, 20'd0,  48'd0,  1'b0},
			'{ROW_ARRIVAL, 40'd4,  40'd1,   5'd0,  1'b0, 20'd0,  48'd0,  1'b0},
			'{ROW_ARRIVAL, 40'd10, 40'd2,   5'd0,  1'b0, 20'd0,  48'd0,  1'b0},
			'{ROW_ARRIVAL, 40'd12, 40'd4,   5'd0,  1'b1, 20'd5,  48'd16, 1'b0},
			'{ROW_ARRIVAL, 40'd13, 40'd7,   5'd0,  1'b0, 20'd0,  48'd0,  1'b0},
			'{ROW_ARRIVAL, 40'd14, 40'd1,   5'd0,  1'b0, 20'd0,  48'd0,  1'b0},
			'{ROW_FLUSH,   ARR_MAX, DUR_MAX, 5'd0, 1'b0, 20'd0,  48'd0,  1'b0},
			'{ROW_FLUSH,   40'd0,  40'd0,   5'd0,  1'b0, 20'd0,  48'd0,  1'b0},
			'{ROW_LIMIT,   40'd0,  40'd0,   5'd0,  1'b0, 20'd0,  48'd0,  1'b0},
			'{ROW_ARRIVAL, 40'd30, 40'd10,  5'd0,  1'b1, 20'd8,  48'd40, 1'b0},
			'{ROW_ARRIVAL, 40'd31, DUR_MAX, 5'd0,  1'b1, 20'd9,  48'd0,  1'b1},
			'{ROW_LIMIT,   40'd0,  40'd0,   5'd1,  1'b0, 20'd0,  48'd0,  1'b0},
			'{ROW_ARRIVAL, 40'd32, 40'd2,   5'd0,  1'b0, 20'd0,  48'd0,  1'b0},
			'{ROW_ARRIVAL, 40'd33, DUR_MAX, 5'd0,  1'b1, 20'd11, 48'd0,  1'b1},
			'{ROW_ARRIVAL, 40'd20, 40'd3,   5'd0,  1'b1, 20'd12, 48'd0,  1'b1},
			'{ROW_ARRIVAL, 40'd45, 40'd5,   5'd0,  1'b0, 20'd0,  48'd0,  1'b0},
			'{ROW_LIMIT,   40'd0,  40'd0,   5'd31, 1'b0, 20'd0,  48'd0,  1'b0}
		};
		phase_limit = '{31, 3, 0, 16, 1, 7};
		phase_dur = '{16, 10, 8, 12, 8, 10};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			case (plan[i].kind)
				ROW_LIMIT: begin
					write_limit(plan[i].lim);
				end
				ROW_FLUSH: begin
					issue(OP_FLUSH, plan[i].t, plan[i].d);
				end
				default: begin
					if (plan[i].typed) begin
						send_request(OP_ARRIVAL, plan[i].t, plan[i].d);
						advance_server(OP_ARRIVAL, plan[i].t, plan[i].d);
						typed_res.id = plan[i].id;
						typed_res.fin = plan[i].fin;
						typed_res.rej = plan[i].rej;
						typed_res.last = 1'b1;
						pending_results.insert(pending_results.size(), typed_res);
					end else begin
						issue(OP_ARRIVAL, plan[i].t, plan[i].d);
					end
				end
			endcase
		end

		t_now = srv_busy[ARR_W-1:0];
		for (int p = 0; p < N_PHASE; p++) begin
			write_limit(LIM_W'(phase_limit[p]));
			send_gap_max = (p == 2 || p == 4) ? 0 : 4;
			recv_gap_max = (p == 2) ? 0 : 4;
			repeat (18) begin
				r = $urandom_range(0, 99);
				if (r < 5) begin
					issue(OP_FLUSH, rand40(), rand40());
				end else begin
					if (r < 7)
						settle_queue();
					if (r < 12) begin
						t = (t_now > 20) ? t_now - $urandom_range(0, 20) : t_now;
					end else begin
						if (r < 17)
							t_now = t_now + ($urandom() >> $urandom_range(4, 31));
						else if (r < 24 && srv_busy < 48'h80_0000_0000)
							t_now = srv_busy[ARR_W-1:0];
						else
							t_now = t_now + $urandom_range(0, 8);
						t = t_now;
					end
					d = ($urandom_range(0, 19) == 0) ? '0 : DUR_W'($urandom_range(1, phase_dur[p]));
					issue(OP_ARRIVAL, t, d);
				end
			end
		end

		// near-maximal times and durations, queue filled to capacity then flushed
		write_limit(LIMIT_RESET);
		send_gap_max = 4;
		recv_gap_max = 4;
		repeat (FULL_ROUNDS) begin
			repeat (DEPTH + 1)
				issue(OP_ARRIVAL, {8'hFF, 32'($urandom())}, {8'hFF, 32'($urandom())});
			issue(OP_FLUSH, rand40(), rand40());
		end

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("bounded_queue_server_sim regression: pass");
		else
			$display("bounded_queue_server_sim regression: fail");
		$finish;
	end

endmodule
